[hdl/kvt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_pkg: key/value table shared types
// Operation and status codes, field widths and the command/status bundles
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package kvt_pkg;

  localparam int KEY_W   = 16;
  localparam int VAL_W   = 16;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } kvt_status_t;

  // controller -> datapath
  typedef struct packed {
    logic        load_req;    // latch request, clear index and hit
    logic        idx_inc;
    logic        rd_next;     // read address is index + 1
    logic        set_hit;
    logic        ins_wr;      // append request pair at count, count + 1
    logic        shift_wr;    // write read-back pair at index
    logic        cnt_dec;
    logic        load_result;
    kvt_status_t status;
  } kvt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              key_match;
    logic              idx_last;   // index is the last stored entry
    logic              next_last;  // index + 1 is the last stored entry
    logic              cnt_zero;
    logic              cnt_full;
    logic              hit;
    logic              out_busy;   // result register full and not taken
    logic [FUNC_W-1:0] func;
  } kvt_stat_t;

endpackage

[hdl/kvt_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_req_if / kvt_rsp_if: request and result channels
// Valid/ready handshake with the payload fields of one item.
// ---------------------------------------------------------------------------
interface kvt_req_if import kvt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic               found;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;
  logic               empty_res;
  logic               full_res;

  modport source (output valid, read_value, found, status, entry_count, empty_res,
                  full_res, input ready);
  modport sink   (input valid, read_value, found, status, entry_count, empty_res,
                  full_res, output ready);
endinterface

[hdl/kvt_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_ctrl: key/value table sequencer
// Steps the serial key search, the insert/delete decision, the shift-down
// after a delete and the hand-off to the result register.
// ---------------------------------------------------------------------------
module kvt_ctrl import kvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  kvt_stat_t stat,
  output kvt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MATCH,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_RESPOND
  } state_t;

  state_t      state, state_next;
  kvt_status_t st_code, st_code_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    st_code_next = st_code;
    cmd          = '0;
    cmd.status   = st_code;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = stat.cnt_zero ? S_DECIDE : S_FETCH;
        end
      end
      S_FETCH: state_next = S_MATCH;
      S_MATCH: begin
        if (stat.key_match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DECIDE;
        end else if (stat.idx_last) begin
          state_next = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_DECIDE: begin
        state_next = S_RESPOND;
        case (stat.func)
          OP_INSERT: begin
            if (stat.hit) begin
              st_code_next = ST_NOCHANGE;
            end else if (stat.cnt_full) begin
              st_code_next = ST_FULL;
            end else begin
              st_code_next = ST_DONE;
              cmd.ins_wr   = 1'b1;
            end
          end
          OP_DELETE: begin
            if (!stat.hit) begin
              st_code_next = ST_NOCHANGE;
            end else begin
              st_code_next = ST_DONE;
              if (stat.idx_last) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                state_next = S_SH_RD;
              end
            end
          end
          default: begin
            st_code_next = stat.hit ? ST_DONE : ST_NOCHANGE;
          end
        endcase
      end
      S_SH_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        if (stat.next_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESPOND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SH_RD;
        end
      end
      S_RESPOND: begin
        if (!stat.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      st_code <= ST_DONE;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

  // request taken only from idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |-> req_valid && state == S_IDLE)
    else $error("request latched outside idle");

  // a search hit always goes on to the decision step
  a_hit_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.set_hit |=> state == S_DECIDE)
    else $error("hit not followed by decision");

  // shift write always preceded by its read
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> $past(cmd.rd_next))
    else $error("shift write without read");

endmodule

[hdl/kvt_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_datapath: key/value table storage and result register
// Key and value memories, search index, pair count, request latch and the
// output register.
// ---------------------------------------------------------------------------
module kvt_datapath import kvt_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  kvt_cmd_t           cmd,
  output kvt_stat_t          stat,
  input  logic               cfg_we,
  input  logic [VAL_W-1:0]   cfg_wdata,
  input  logic [FUNC_W-1:0]  req_func,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [VAL_W-1:0]   req_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [VAL_W-1:0]   rsp_read_value,
  output logic               rsp_found,
  output logic [1:0]         rsp_status,
  output logic [COUNT_W-1:0] rsp_entry_count,
  output logic               rsp_empty_res,
  output logic               rsp_full_res
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic [KEY_W-1:0]  key_mem [MAX_ENTRIES];
  logic [VAL_W-1:0]  val_mem [MAX_ENTRIES];

  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic              hit;
  logic [VAL_W-1:0]  missing_value;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  logic [IDX_W:0]         rd_addr_ext;
  logic [IDX_W-1:0]       rd_addr;
  logic [CNT_W:0]         idx_p1, idx_p2;
  logic [CNT_W+COUNT_W:0] cnt_ext;

  assign rd_addr_ext = {1'b0, idx} + (IDX_W+1)'(cmd.rd_next);
  assign rd_addr     = rd_addr_ext[IDX_W-1:0];
  assign idx_p1      = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
  assign idx_p2      = (CNT_W+1)'(idx) + (CNT_W+1)'(2);
  assign cnt_ext     = (CNT_W+COUNT_W+1)'(count);

  always_comb begin
    stat.key_match = (rd_key == key);
    stat.idx_last  = (idx_p1 >= {1'b0, count});
    stat.next_last = (idx_p2 == {1'b0, count});
    stat.cnt_zero  = (count == '0);
    stat.cnt_full  = (count == CNT_MAX);
    stat.hit       = hit;
    stat.out_busy  = rsp_valid && !rsp_ready;
    stat.func      = func;
  end

  // memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[IDX_W'(count)] <= key;
      val_mem[IDX_W'(count)] <= value;
    end else if (cmd.shift_wr) begin
      key_mem[idx] <= rd_key;
      val_mem[idx] <= rd_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func  <= req_func;
      key   <= req_key;
      value <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      count         <= '0;
      hit           <= 1'b0;
      missing_value <= '1;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        missing_value <= cfg_wdata;
      end
      if (cmd.load_req) begin
        idx <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + IDX_W'(1);
        end
        if (cmd.set_hit) begin
          hit <= 1'b1;
        end
      end
      if (cmd.ins_wr) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp_read_value  <= (hit && func != OP_INSERT && func != OP_DELETE) ?
                         rd_val : missing_value;
      rsp_found       <= hit;
      rsp_status      <= cmd.status;
      rsp_entry_count <= cnt_ext[COUNT_W-1:0];
      rsp_empty_res   <= (count == '0);
      rsp_full_res    <= (count == CNT_MAX);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("pair count beyond capacity");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> count < CNT_MAX && !hit)
    else $error("append into full table or duplicate key");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |=> count == $past(count) + CNT_W'(1))
    else $error("count not advanced after append");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(rsp_valid && !rsp_ready))
    else $error("result register overwritten");

endmodule

[hdl/key_value_table_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_value_table_unit: small associative key/value table
// Up to MAX_ENTRIES pairs packed in insertion order; lookup, insert, delete.
// ---------------------------------------------------------------------------
// Sequence: a request fetches and compares the stored keys in order until
//   the match or the last entry, then decides; a delete then moves each
//   later entry down with a read and a write, and the result is loaded.
// Throughput: one request at a time, taken the cycle after the previous result
//   is loaded, so a new request waits for the search, the decision and any
//   shift-down, longer while a result waits on the sink.
//   Set by the single read port shared by the search and the shift-down.
// Reset: empties the table (pair count 0) and sets missing_value to 0xFFFF.
//   Memory contents are not cleared; no entry past the count is ever used.
module key_value_table_unit import kvt_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata,
  kvt_req_if.sink          req,
  kvt_rsp_if.source        rsp
);

  // Command and status bundles between sequencer and datapath.
  kvt_cmd_t  cmd;
  kvt_stat_t stat;

  // Sequencer: owns the request ready (high only while idle) and steps
  // fetch/compare pairs through the key memory, then decides the outcome.
  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: memories, index and count, the missing_value register and the
  // result register. The result register frees the sequencer to take the
  // next request while a finished result still waits on the sink side.
  kvt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_func        (req.func),
    .req_key         (req.key),
    .req_value       (req.value),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_value  (rsp.read_value),
    .rsp_found       (rsp.found),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count),
    .rsp_empty_res   (rsp.empty_res),
    .rsp_full_res    (rsp.full_res)
  );

endmodule

[bench/key_value_table_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_value_table_unit_tb: self-checking bench for the key/value table
// Drives lookup, insert and delete requests with bursty timing against a
// stalling result port. A tracker class keeps its own copy of the table,
// predicts every result and checks it field by field in order.
// ---------------------------------------------------------------------------
module key_value_table_unit_tb;
  import kvt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // settle time after the final drain, scaled with the table depth
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int POOL_SIZE   = 20;   // a bit over the depth, so inserts hit full
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  // code 3 is unused by the block and must behave as a lookup
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               empty_res;
    logic               full_res;
  } table_result_t;

  // Keeps a shadow of the table and the results still owed by the block.
  class table_tracker;
    logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [VAL_W-1:0] val_tab [TABLE_DEPTH];
    int unsigned      fill;
    logic [VAL_W-1:0] miss_val;
    table_result_t    pending_results [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      hits;
    int unsigned      refused;
    int unsigned      removed;

    function new();
      fill     = 0;
      miss_val = 16'hFFFF;
      errors   = 0;
      checked  = 0;
      hits     = 0;
      refused  = 0;
      removed  = 0;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Apply one accepted request to the shadow table, queue its result.
    function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      int unsigned   pos;
      bit            hit;
      kvt_status_t   st;
      table_result_t res;
      pos = fill;
      for (int i = 0; i < fill; i++) begin
        if (pos == fill && key_tab[i] == key) pos = i;
      end
      hit = (pos < fill);
      res.read_value = miss_val;
      if (func == OP_INSERT) begin
        if (hit) begin
          st = ST_NOCHANGE;
        end else if (fill >= TABLE_DEPTH) begin
          st = ST_FULL;
          refused++;
        end else begin
          key_tab[fill] = key;
          val_tab[fill] = value;
          fill++;
          st = ST_DONE;
        end
      end else if (func == OP_DELETE) begin
        if (hit) begin
          for (int j = pos; j + 1 < fill; j++) begin
            key_tab[j] = key_tab[j+1];
            val_tab[j] = val_tab[j+1];
          end
          fill--;
          removed++;
          st = ST_DONE;
        end else begin
          st = ST_NOCHANGE;
        end
      end else begin
        if (hit) begin
          res.read_value = val_tab[pos];
          hits++;
          st = ST_DONE;
        end else begin
          st = ST_NOCHANGE;
        end
      end
      res.found       = hit;
      res.status      = st;
      res.entry_count = COUNT_W'(fill);
      res.empty_res   = (fill == 0);
      res.full_res    = (fill >= TABLE_DEPTH);
      pending_results.push_back(res);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        flag("unexpected result", 32'h0, 32'(got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.read_value !== want.read_value)
        flag("read_value", 32'(want.read_value), 32'(got.read_value));
      if (got.found !== want.found)
        flag("found", 32'(want.found), 32'(got.found));
      if (got.status !== want.status)
        flag("status", 32'(want.status), 32'(got.status));
      if (got.entry_count !== want.entry_count)
        flag("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      if (got.empty_res !== want.empty_res)
        flag("empty_res", 32'(want.empty_res), 32'(got.empty_res));
      if (got.full_res !== want.full_res)
        flag("full_res", 32'(want.full_res), 32'(got.full_res));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [VAL_W-1:0] cfg_wdata;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  table_tracker tracker = new();

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      sent_requests = 0;
  int unsigned      cfg_writes    = 0;

  key_value_table_unit #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: the ready pattern is switched at random between never
  // stalling, short sparse stalls and long frequent ones.
  int unsigned rx_cycles  = 0;
  int unsigned rx_mode    = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    rx_cycles++;
    if (rx_cycles % 400 == 0) rx_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      case (rx_mode)
        0: begin
        end
        1: begin
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(2, 16);
        end
      endcase
    end
  end

  // Monitor: values seen here are the ones from before the edge, so the
  // handshake check does not depend on process order.
  always @(posedge clk) begin
    table_result_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        tracker.note_request(req_ch.func, req_ch.key, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.read_value  = rsp_ch.read_value;
        got.found       = rsp_ch.found;
        got.status      = rsp_ch.status;
        got.entry_count = rsp_ch.entry_count;
        got.empty_res   = rsp_ch.empty_res;
        got.full_res    = rsp_ch.full_res;
        tracker.check_result(got);
      end
    end
  end

  // Present one request and hold it until the block takes it. Valid stays
  // high on return so back-to-back requests need no extra assignment.
  task automatic send_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                              logic [VAL_W-1:0] v);
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.key   <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_requests++;
  endtask

  task automatic idle_gap(int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain();
    idle_gap(1);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Only called on an idle block, right after drain().
  task automatic write_missing(logic [VAL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.miss_val = v;
    cfg_writes++;
  endtask

  task automatic refill_pool(bit with_edges);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());
    if (with_edges) begin
      key_pool[0] = '0;
      key_pool[1] = '1;
    end
  endtask

  // Mostly keys from a small pool so hits, duplicates and a full table are
  // common; one in ten is a fresh random key. Bursts of random length.
  task automatic random_phase(int unsigned count, int unsigned ins_pct,
                              int unsigned del_pct);
    int unsigned       burst;
    int unsigned       r;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;
    burst = $urandom_range(1, 24);
    for (int unsigned n = 0; n < count; n++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < ins_pct)                f = OP_INSERT;
      else if (r < ins_pct + del_pct) f = OP_DELETE;
      else if (r < 95)                f = OP_LOOKUP;
      else                            f = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom());
      else                           k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(f, k, VAL_W'($urandom()));
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.func  = OP_LOOKUP;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_gap(2);

    // Directed part, with missing_value still at its reset value.
    send_request(OP_LOOKUP, 16'h1234, 16'h0000);   // miss on empty table
    send_request(OP_DELETE, 16'h1234, 16'h0000);   // delete on empty table
    send_request(OP_INSERT, 16'h0000, 16'h0000);
    send_request(OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(OP_INSERT, 16'h0000, 16'hABCD);   // duplicate key, no change
    send_request(OP_LOOKUP, 16'h0000, 16'hFFFF);
    send_request(OP_UNUSED, 16'hFFFF, 16'h0000);   // unused code acts as lookup
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      send_request(OP_INSERT, 16'h5A00 + 16'(i), ~(16'h5A00 + 16'(i)));
    send_request(OP_INSERT, 16'h1234, 16'h4321);   // full, new key refused
    send_request(OP_INSERT, 16'hFFFF, 16'h0001);   // full, key present
    send_request(OP_LOOKUP, 16'h5A0D, 16'h0000);   // hit on the deepest entry
    send_request(OP_DELETE, 16'h0000, 16'h0000);   // first entry, all shift down
    send_request(OP_DELETE, 16'h5A0D, 16'h0000);   // last entry, nothing moves
    send_request(OP_DELETE, 16'h5A05, 16'h0000);   // middle entry
    send_request(OP_LOOKUP, 16'h5A06, 16'h0000);   // moved entry still found
    send_request(OP_LOOKUP, 16'h0000, 16'h0000);   // deleted key now misses

    // Random phases, each with its own missing_value and op mix.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_missing(16'h0000);
        1: write_missing(16'hFFFF);
        2: write_missing(16'h8000);
        3: write_missing(16'h0001);
        4: write_missing(16'h7FFF);
        default: write_missing(VAL_W'($urandom()));
      endcase
      refill_pool(p % 2 == 0);
      case (p % 3)
        0: random_phase(PHASE_ITEMS, 60, 15);   // fill up, hit full often
        1: random_phase(PHASE_ITEMS, 20, 50);   // drain down to empty
        default: random_phase(PHASE_ITEMS, 40, 30);
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests under %0d missing_value settings, %0d results checked.",
             sent_requests, cfg_writes + 1, tracker.checked);
    $display("Saw %0d lookup hits, %0d deletes and %0d inserts refused on a full table.",
             tracker.hits, tracker.removed, tracker.refused);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("key_value_table_unit verification clean");
    end else begin
      $display("key_value_table_unit verification failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run (about 2 ms).
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", tracker.pending_results.size());
    $display("key_value_table_unit verification failed");
    $finish;
  end

endmodule
